[hw/rtl/sm83_instruction_execute_defines.svh]
// assertion macros for the sm83 instruction execute block
// expects clk and rst_n in the scope of each use
`ifndef SM83_INSTRUCTION_EXECUTE_DEFINES_SVH
`define SM83_INSTRUCTION_EXECUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define SM83_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sm83 check failed");
`define SM83_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sm83 forbidden condition");
`else
`define SM83_ASSERT(lbl, prop)
`define SM83_ASSERT_NEVER(lbl, cond)
`endif
`endif

[hw/rtl/sm83_pkg.sv]
// shared types and constants of the sm83 instruction execute block
// no dependencies
package sm83_pkg;

    // request kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_EXEC   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_STOP      = 2'd1;
    localparam logic [1:0] ST_UNHANDLED = 2'd2;

    // register reset values
    localparam logic [15:0] PC_RESET  = 16'h0100;
    localparam logic [15:0] REG_RESET = 16'hffff;
    localparam logic [7:0]  MEM_FILL  = 8'hff;

    // alu operation codes, same order as opcode bits 5..3
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBC = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CP  = 3'd7
    } alu_op_t;

    // alu result and flags
    typedef struct packed {
        logic [7:0] r;
        logic       z;
        logic       n;
        logic       h;
        logic       c;
        logic       wr_a;
    } alu_res_t;

endpackage

[hw/rtl/sm83_instruction_execute.sv]
// top level of the sm83 instruction execute block: sequencer and registers
// depends on sm83_pkg, sm83_alu, sm83_mem and the assertion macro header
//
// Requests come in on s_tvalid/s_tready/s_tdata, one result per request goes
// out on m_tvalid/m_tready/m_tdata. A write request stores one byte, a read
// request returns one byte, an execute request runs the instruction at pc.
// The block works on one request at a time over a single-port memory:
// a write request goes through the write step, a read through the read and
// capture steps, an unused kind straight to the result step, and an execute
// request through three fetch reads and a latch step, two operand reads, the
// execute step, up to two writes and the result step; the memory port sets
// these steps. After reset the memory is filled with 0xff, one byte per
// cycle, and s_tready stays low during that pass. Registers reset to pc
// 0x0100 and 0xffff for sp, af, bc, de and hl.
// A result waits in an output register; a new request is taken while it
// waits, but that request's result is held until the receiver takes the
// previous one, so a stalled receiver stalls the block after one request.
`include "sm83_instruction_execute_defines.svh"
module sm83_instruction_execute #(
    parameter int ADDR_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // kind[1:0], address[17:2], data[25:18], zero pad
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], pc_out[17:2], sp_out[33:18], af_out[49:34], bc_out[65:50],
    // de_out[81:66], hl_out[97:82], read_byte[105:98], zero pad
    output logic [111:0] m_tdata
);
    import sm83_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_WR    = 15'b000000000000100,
        S_RD    = 15'b000000000001000,
        S_RDC   = 15'b000000000010000,
        S_OP    = 15'b000000000100000,
        S_N1    = 15'b000000001000000,
        S_N2    = 15'b000000010000000,
        S_HI    = 15'b000000100000000,
        S_M1    = 15'b000001000000000,
        S_M2    = 15'b000010000000000,
        S_EX    = 15'b000100000000000,
        S_W1    = 15'b001000000000000,
        S_W2    = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next, af_reg, af_next;
    logic [15:0] bc_reg, bc_next, de_reg, de_next, hl_reg, hl_next;
    logic        out_valid_reg, out_valid_next;

    // payload registers
    logic [1:0]   kind_reg;
    logic [15:0]  addr_reg;
    logic [7:0]   data_reg;
    logic [7:0]   op_reg, n8_reg, hi_reg, m0_reg, rb_reg;
    logic [1:0]   status_reg;
    logic         wtwo_reg;
    logic [15:0]  wa1_reg, wa2_reg;
    logic [7:0]   wd1_reg, wd2_reg;
    logic [111:0] out_reg;

    // memory port
    logic        mem_we, mem_re;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata, mem_rdata;

    // shared unit
    alu_op_t     alu_op;
    logic [7:0]  alu_a, alu_v;
    logic        alu_cin;
    alu_res_t    alu_res;
    logic [15:0] add_x, add_y, add_sum;

    // execute step results
    logic [15:0] ex_pc, ex_sp, ex_bc, ex_de, ex_hl;
    logic [7:0]  ex_a, ex_f;
    logic [1:0]  ex_status;
    logic        ex_wone, ex_wtwo;
    logic [15:0] ex_wa1, ex_wa2;
    logic [7:0]  ex_wd1, ex_wd2;

    logic [15:0] n16, ma;
    logic        accept, out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign n16      = {hi_reg, n8_reg};
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // 8-bit register read by operand code
    function automatic logic [7:0] getr(input logic [2:0] i, input logic [15:0] bc,
                                        input logic [15:0] de, input logic [15:0] hl,
                                        input logic [7:0] a, input logic [7:0] m);
        logic [7:0] v;
        case (i)
            3'd0:    v = bc[15:8];
            3'd1:    v = bc[7:0];
            3'd2:    v = de[15:8];
            3'd3:    v = de[7:0];
            3'd4:    v = hl[15:8];
            3'd5:    v = hl[7:0];
            3'd6:    v = m;
            default: v = a;
        endcase
        return v;
    endfunction

    sm83_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr[ADDR_BITS-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    sm83_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .v     (alu_v),
        .cin   (alu_cin),
        .add_x (add_x),
        .add_y (add_y),
        .res   (alu_res),
        .sum   (add_sum)
    );

    // memory operand address of the current opcode
    always_comb
    begin
        if (op_reg == 8'hf0)
            ma = {8'hff, n8_reg};
        else if (op_reg == 8'hf2)
            ma = {8'hff, bc_reg[7:0]};
        else if (op_reg == 8'hfa)
            ma = n16;
        else if (op_reg >= 8'hc0)
            ma = sp_reg;
        else if (op_reg < 8'h40 && op_reg[2:0] == 3'd2)
            ma = (op_reg[5:4] == 2'd0) ? bc_reg : (op_reg[5:4] == 2'd1) ? de_reg : hl_reg;
        else
            ma = hl_reg;
    end

    // alu operand selection: inc/dec use it on the target register
    always_comb
    begin
        if (op_reg < 8'h40 && (op_reg[2:0] == 3'd4 || op_reg[2:0] == 3'd5))
        begin
            alu_op  = (op_reg[0]) ? ALU_SUB : ALU_ADD;
            alu_a   = getr(op_reg[5:3], bc_reg, de_reg, hl_reg, af_reg[15:8], m0_reg);
            alu_v   = 8'd1;
            alu_cin = 1'b0;
        end
        else
        begin
            alu_op  = alu_op_t'(op_reg[5:3]);
            alu_a   = af_reg[15:8];
            alu_v   = (op_reg >= 8'hc0) ? n8_reg
                    : getr(op_reg[2:0], bc_reg, de_reg, hl_reg, af_reg[15:8], m0_reg);
            alu_cin = af_reg[4];
        end
    end

    // adder operands by sequencer step
    always_comb
    begin
        case (state_reg)
            S_N1:
            begin
                add_x = pc_reg;
                add_y = 16'd1;
            end
            S_N2:
            begin
                add_x = pc_reg;
                add_y = 16'd2;
            end
            S_M2:
            begin
                add_x = ma;
                add_y = 16'd1;
            end
            default:
            begin
                add_x = pc_reg;
                add_y = 16'd3;
            end
        endcase
    end

    // execute step
    always_comb
    begin
        logic [7:0]  a, m1, sv, rr;
        logic        zf, nf, hf, cf, taken, do_set, cy;
        logic [2:0]  si;
        logic [15:0] pc1, pc2, pc3, pv, pushv, sext;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [8:0]  s9;
        logic [4:0]  s5;

        a     = af_reg[15:8];
        m1    = mem_rdata;
        zf    = af_reg[7];
        nf    = af_reg[6];
        hf    = af_reg[5];
        cf    = af_reg[4];
        case (op_reg[4:3])
            2'd0:    taken = !zf;
            2'd1:    taken = zf;
            2'd2:    taken = !cf;
            default: taken = cf;
        endcase
        pc1   = pc_reg + 16'd1;
        pc2   = pc_reg + 16'd2;
        pc3   = add_sum;
        sext  = {{8{n8_reg[7]}}, n8_reg};
        case (op_reg[5:4])
            2'd0:    pv = bc_reg;
            2'd1:    pv = de_reg;
            2'd2:    pv = hl_reg;
            default: pv = sp_reg;
        endcase
        pushv  = (op_reg[5:4] == 2'd3) ? af_reg : pv;
        do_set = 1'b0;
        si     = op_reg[5:3];
        sv     = 8'd0;
        rr     = a;
        cy     = cf;
        s17    = '0;
        s13    = '0;
        s9     = '0;
        s5     = '0;

        ex_pc     = pc1;
        ex_sp     = sp_reg;
        ex_a      = a;
        ex_f      = af_reg[7:0];
        ex_bc     = bc_reg;
        ex_de     = de_reg;
        ex_hl     = hl_reg;
        ex_status = ST_OK;
        ex_wone   = 1'b0;
        ex_wtwo   = 1'b0;
        ex_wa1    = hl_reg;
        ex_wd1    = 8'd0;
        ex_wa2    = hl_reg;
        ex_wd2    = 8'd0;

        if (op_reg >= 8'h40 && op_reg < 8'h80)
        begin
            if (op_reg == 8'h76)
                ex_status = ST_STOP;
            else
            begin
                do_set = 1'b1;
                sv     = getr(op_reg[2:0], bc_reg, de_reg, hl_reg, a, m0_reg);
            end
        end
        else if ((op_reg >= 8'h80 && op_reg < 8'hc0) ||
                 (op_reg >= 8'hc0 && op_reg[2:0] == 3'd6))
        begin
            if (alu_res.wr_a)
                ex_a = alu_res.r;
            ex_f = {alu_res.z, alu_res.n, alu_res.h, alu_res.c, 4'd0};
            if (op_reg >= 8'hc0)
                ex_pc = pc2;
        end
        else if (op_reg < 8'h40 && (op_reg[2:0] == 3'd4 || op_reg[2:0] == 3'd5))
        begin
            do_set = 1'b1;
            sv     = alu_res.r;
            ex_f   = {alu_res.z, alu_res.n, alu_res.h, cf, 4'd0};
        end
        else if (op_reg < 8'h40 && op_reg[2:0] == 3'd6)
        begin
            do_set = 1'b1;
            sv     = n8_reg;
            ex_pc  = pc2;
        end
        else if (op_reg >= 8'hc0 && op_reg[2:0] == 3'd7)
        begin
            ex_wtwo = 1'b1;
            ex_wa1  = sp_reg - 16'd1;
            ex_wd1  = pc1[15:8];
            ex_wa2  = sp_reg - 16'd2;
            ex_wd2  = pc1[7:0];
            ex_sp   = sp_reg - 16'd2;
            ex_pc   = {10'd0, op_reg[5:3], 3'd0};
        end
        else if (op_reg < 8'h40 && (op_reg[3:0] == 4'h1 || op_reg[3:0] == 4'h3 ||
                                   op_reg[3:0] == 4'hb))
        begin
            if (op_reg[3:0] == 4'h1)
            begin
                pv    = n16;
                ex_pc = pc3;
            end
            else if (op_reg[3:0] == 4'h3)
                pv = pv + 16'd1;
            else
                pv = pv - 16'd1;
            case (op_reg[5:4])
                2'd0:    ex_bc = pv;
                2'd1:    ex_de = pv;
                2'd2:    ex_hl = pv;
                default: ex_sp = pv;
            endcase
        end
        else if (op_reg < 8'h40 && op_reg[3:0] == 4'h9)
        begin
            s17   = {1'b0, hl_reg} + {1'b0, pv};
            s13   = {1'b0, hl_reg[11:0]} + {1'b0, pv[11:0]};
            ex_f  = {zf, 1'b0, s13[12], s17[16], 4'd0};
            ex_hl = s17[15:0];
        end
        else if (op_reg < 8'h40 && (op_reg[3:0] == 4'h2 || op_reg[3:0] == 4'ha))
        begin
            if (op_reg[3])
                ex_a = m0_reg;
            else
            begin
                ex_wone = 1'b1;
                ex_wa1  = ma;
                ex_wd1  = a;
            end
            if (op_reg[5:4] == 2'd2)
                ex_hl = hl_reg + 16'd1;
            if (op_reg[5:4] == 2'd3)
                ex_hl = hl_reg - 16'd1;
        end
        else if (op_reg >= 8'hc0 && op_reg[3:0] == 4'h1)
        begin
            ex_sp = sp_reg + 16'd2;
            case (op_reg[5:4])
                2'd0:    ex_bc = {m1, m0_reg};
                2'd1:    ex_de = {m1, m0_reg};
                2'd2:    ex_hl = {m1, m0_reg};
                default:
                begin
                    ex_a = m1;
                    ex_f = {m0_reg[7:4], 4'd0};
                end
            endcase
        end
        else if (op_reg >= 8'hc0 && op_reg[3:0] == 4'h5)
        begin
            ex_wtwo = 1'b1;
            ex_wa1  = sp_reg - 16'd1;
            ex_wd1  = pushv[15:8];
            ex_wa2  = sp_reg - 16'd2;
            ex_wd2  = pushv[7:0];
            ex_sp   = sp_reg - 16'd2;
        end
        else
        begin
            case (op_reg)
                8'h00, 8'hf3, 8'hfb: ex_pc = pc1;
                8'h10:
                begin
                    ex_pc     = pc2;
                    ex_status = ST_STOP;
                end
                8'h07, 8'h0f, 8'h17, 8'h1f:
                begin
                    case (op_reg[4:3])
                        2'd0:    rr = {a[6:0], a[7]};
                        2'd1:    rr = {a[0], a[7:1]};
                        2'd2:    rr = {a[6:0], cf};
                        default: rr = {cf, a[7:1]};
                    endcase
                    ex_a = rr;
                    ex_f = {3'd0, op_reg[3] ? a[0] : a[7], 4'd0};
                end
                8'h27:
                begin
                    rr = a;
                    if (!nf)
                    begin
                        if (cf || a > 8'h99)
                        begin
                            rr = rr + 8'h60;
                            cy = 1'b1;
                        end
                        if (hf || rr[3:0] > 4'd9)
                            rr = rr + 8'h06;
                    end
                    else
                    begin
                        if (cf)
                            rr = rr - 8'h60;
                        if (hf)
                            rr = rr - 8'h06;
                    end
                    ex_a = rr;
                    ex_f = {rr == 8'd0, nf, 1'b0, cy, 4'd0};
                end
                8'h2f:
                begin
                    ex_a = ~a;
                    ex_f = {zf, 1'b1, 1'b1, cf, 4'd0};
                end
                8'h37: ex_f = {zf, 1'b0, 1'b0, 1'b1, 4'd0};
                8'h3f: ex_f = {zf, 1'b0, 1'b0, !cf, 4'd0};
                8'h08:
                begin
                    ex_wtwo = 1'b1;
                    ex_wa1  = n16;
                    ex_wd1  = sp_reg[7:0];
                    ex_wa2  = n16 + 16'd1;
                    ex_wd2  = sp_reg[15:8];
                    ex_pc   = pc3;
                end
                8'h18, 8'h20, 8'h28, 8'h30, 8'h38:
                    ex_pc = (op_reg == 8'h18 || taken) ? pc2 + sext : pc2;
                8'hc0, 8'hc8, 8'hd0, 8'hd8:
                begin
                    if (taken)
                    begin
                        ex_pc = {m1, m0_reg};
                        ex_sp = sp_reg + 16'd2;
                    end
                end
                8'hc9, 8'hd9:
                begin
                    ex_pc = {m1, m0_reg};
                    ex_sp = sp_reg + 16'd2;
                end
                8'hc2, 8'hca, 8'hd2, 8'hda: ex_pc = taken ? n16 : pc3;
                8'hc3: ex_pc = n16;
                8'hc4, 8'hcc, 8'hd4, 8'hdc, 8'hcd:
                begin
                    ex_pc = pc3;
                    if (op_reg == 8'hcd || taken)
                    begin
                        ex_wtwo = 1'b1;
                        ex_wa1  = sp_reg - 16'd1;
                        ex_wd1  = pc3[15:8];
                        ex_wa2  = sp_reg - 16'd2;
                        ex_wd2  = pc3[7:0];
                        ex_sp   = sp_reg - 16'd2;
                        ex_pc   = n16;
                    end
                end
                8'he0, 8'he2, 8'hea:
                begin
                    ex_wone = 1'b1;
                    ex_wd1  = a;
                    case (op_reg)
                        8'he0:
                        begin
                            ex_wa1 = {8'hff, n8_reg};
                            ex_pc  = pc2;
                        end
                        8'he2:   ex_wa1 = {8'hff, bc_reg[7:0]};
                        default:
                        begin
                            ex_wa1 = n16;
                            ex_pc  = pc3;
                        end
                    endcase
                end
                8'hf0:
                begin
                    ex_a  = m0_reg;
                    ex_pc = pc2;
                end
                8'hf2: ex_a = m0_reg;
                8'hfa:
                begin
                    ex_a  = m0_reg;
                    ex_pc = pc3;
                end
                8'he8, 8'hf8:
                begin
                    s5   = {1'b0, sp_reg[3:0]} + {1'b0, n8_reg[3:0]};
                    s9   = {1'b0, sp_reg[7:0]} + {1'b0, n8_reg};
                    ex_f = {2'b00, s5[4], s9[8], 4'd0};
                    if (op_reg == 8'he8)
                        ex_sp = sp_reg + sext;
                    else
                        ex_hl = sp_reg + sext;
                    ex_pc = pc2;
                end
                8'he9: ex_pc = hl_reg;
                8'hf9: ex_sp = hl_reg;
                default:
                begin
                    ex_pc     = pc_reg;
                    ex_status = ST_UNHANDLED;
                end
            endcase
        end

        // 8-bit register or (hl) write-back
        if (do_set)
        begin
            case (si)
                3'd0: ex_bc = {sv, bc_reg[7:0]};
                3'd1: ex_bc = {bc_reg[15:8], sv};
                3'd2: ex_de = {sv, de_reg[7:0]};
                3'd3: ex_de = {de_reg[15:8], sv};
                3'd4: ex_hl = {sv, hl_reg[7:0]};
                3'd5: ex_hl = {hl_reg[15:8], sv};
                3'd6:
                begin
                    ex_wone = 1'b1;
                    ex_wa1  = hl_reg;
                    ex_wd1  = sv;
                end
                default: ex_a = sv;
            endcase
        end
    end

    // sequencer and memory port
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        af_next        = af_reg;
        bc_next        = bc_reg;
        de_next        = de_reg;
        hl_next        = hl_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = pc_reg;
        mem_wdata      = MEM_FILL;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = 16'(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tdata[1:0])
                        KIND_WRITE: state_next = S_WR;
                        KIND_READ:  state_next = S_RD;
                        KIND_EXEC:  state_next = S_OP;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_WR:
            begin
                mem_we     = 1'b1;
                mem_addr   = addr_reg;
                mem_wdata  = data_reg;
                state_next = S_DONE;
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = addr_reg;
                state_next = S_RDC;
            end
            S_RDC: state_next = S_DONE;
            S_OP:
            begin
                mem_re     = 1'b1;
                state_next = S_N1;
            end
            S_N1:
            begin
                mem_re     = 1'b1;
                mem_addr   = add_sum;
                state_next = S_N2;
            end
            S_N2:
            begin
                mem_re     = 1'b1;
                mem_addr   = add_sum;
                state_next = S_HI;
            end
            S_HI: state_next = S_M1;
            S_M1:
            begin
                mem_re     = 1'b1;
                mem_addr   = ma;
                state_next = S_M2;
            end
            S_M2:
            begin
                mem_re     = 1'b1;
                mem_addr   = add_sum;
                state_next = S_EX;
            end
            S_EX:
            begin
                pc_next    = ex_pc;
                sp_next    = ex_sp;
                af_next    = {ex_a, ex_f};
                bc_next    = ex_bc;
                de_next    = ex_de;
                hl_next    = ex_hl;
                state_next = (ex_wone || ex_wtwo) ? S_W1 : S_DONE;
            end
            S_W1:
            begin
                mem_we     = 1'b1;
                mem_addr   = wa1_reg;
                mem_wdata  = wd1_reg;
                state_next = wtwo_reg ? S_W2 : S_DONE;
            end
            S_W2:
            begin
                mem_we     = 1'b1;
                mem_addr   = wa2_reg;
                mem_wdata  = wd2_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= PC_RESET;
            sp_reg        <= REG_RESET;
            af_reg        <= REG_RESET;
            bc_reg        <= REG_RESET;
            de_reg        <= REG_RESET;
            hl_reg        <= REG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            af_reg        <= af_next;
            bc_reg        <= bc_next;
            de_reg        <= de_next;
            hl_reg        <= hl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tdata[1:0];
            addr_reg   <= s_tdata[17:2];
            data_reg   <= s_tdata[25:18];
            rb_reg     <= 8'd0;
            status_reg <= ST_OK;
        end
        if (state_reg == S_RDC && kind_reg == KIND_READ)
            rb_reg <= mem_rdata;
        if (state_reg == S_N1)
            op_reg <= mem_rdata;
        if (state_reg == S_N2)
            n8_reg <= mem_rdata;
        if (state_reg == S_HI)
            hi_reg <= mem_rdata;
        if (state_reg == S_M2)
            m0_reg <= mem_rdata;
        if (state_reg == S_EX)
        begin
            status_reg <= ex_status;
            wtwo_reg   <= ex_wtwo;
            wa1_reg    <= ex_wa1;
            wd1_reg    <= ex_wd1;
            wa2_reg    <= ex_wa2;
            wd2_reg    <= ex_wd2;
        end
        if (state_reg == S_DONE && out_free)
            out_reg <= {6'd0, rb_reg, hl_reg, de_reg, bc_reg, af_reg, sp_reg, pc_reg,
                        status_reg};
    end

    // checks
    `SM83_ASSERT_NEVER(a_mem_one_access, mem_we && mem_re)
    `SM83_ASSERT(a_busy_after_accept, accept |=> !s_tready)
    `SM83_ASSERT(a_clear_sweep, (state_reg == S_CLEAR && $past(rst_n)) |-> clr_reg == ADDR_BITS'($past(clr_reg) + 1'b1))
endmodule

[hw/rtl/sm83_mem.sv]
// byte memory of the sm83 block, one port, registered read data
// depends on nothing
module sm83_mem #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [7:0]           wdata,
    output logic [7:0]           rdata
);
    logic [7:0] mem_q [2**ADDR_BITS];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[addr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_q[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/sm83_alu.sv]
// shared arithmetic unit: 8-bit alu with flags and a 16-bit adder
// depends on sm83_pkg
module sm83_alu (
    input  sm83_pkg::alu_op_t  op,
    input  logic [7:0]         a,
    input  logic [7:0]         v,
    input  logic               cin,
    input  logic [15:0]        add_x,
    input  logic [15:0]        add_y,
    output sm83_pkg::alu_res_t res,
    output logic [15:0]        sum
);
    import sm83_pkg::*;

    logic [8:0] wide;
    logic [4:0] nib;
    logic       c;

    // 8-bit operation
    always_comb
    begin
        res  = '0;
        c    = 1'b0;
        wide = '0;
        nib  = '0;
        res.wr_a = (op != ALU_CP);
        case (op)
            ALU_ADD, ALU_ADC:
            begin
                c    = (op == ALU_ADC) ? cin : 1'b0;
                wide = {1'b0, a} + {1'b0, v} + {8'd0, c};
                nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
                res.r = wide[7:0];
                res.h = nib[4];
                res.c = wide[8];
            end
            ALU_SUB, ALU_SBC, ALU_CP:
            begin
                c    = (op == ALU_SBC) ? cin : 1'b0;
                wide = {1'b0, a} - {1'b0, v} - {8'd0, c};
                nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
                res.r = wide[7:0];
                res.n = 1'b1;
                res.h = nib[4];
                res.c = wide[8];
            end
            ALU_AND:
            begin
                res.r = a & v;
                res.h = 1'b1;
            end
            ALU_XOR: res.r = a ^ v;
            ALU_OR:  res.r = a | v;
            default: res.r = a;
        endcase
        res.z = (res.r == 8'd0);
    end

    // address and counter adder
    assign sum = add_x + add_y;
endmodule
